// ----- rtl/tpip_pkg.sv -----
// Shared types and constants for the tree-prefix indent parser.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package tpip_pkg;

  // Field widths of the character and result beats
  localparam int CHAR_W   = 21;
  localparam int PREV_W   = 6;
  localparam int INDENT_W = 7;
  localparam int PREFIX_W = 8;

  // Defaults for the top-level parameters
  localparam int TAB_WIDTH_DEF        = 4;
  localparam int MAX_PREFIX_CHARS_DEF = 255;

  // Code points of the prefix glyphs
  localparam logic [CHAR_W-1:0] CP_SPACE  = 21'h00020;
  localparam logic [CHAR_W-1:0] CP_NBSP   = 21'h000A0;
  localparam logic [CHAR_W-1:0] CP_VBAR   = 21'h02502;
  localparam logic [CHAR_W-1:0] CP_TEE    = 21'h0251C;
  localparam logic [CHAR_W-1:0] CP_CORNER = 21'h02514;
  localparam logic [CHAR_W-1:0] CP_HBAR   = 21'h02500;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_VLINE  = 3'd1,
    ST_VCONT  = 3'd2,
    ST_BRANCH = 3'd3,
    ST_HLINE  = 3'd4
  } parse_state_t;

  typedef enum logic [2:0] {
    CH_SPACE,
    CH_VBAR,
    CH_BRANCH,
    CH_HBAR,
    CH_OTHER
  } char_class_t;

  // Parser control state handed between the step logic and the top level
  typedef struct packed {
    parse_state_t state;
    logic         marker_seen;
  } parse_ctl_t;

  typedef struct packed {
    logic [INDENT_W-1:0] indent_depth;
    logic                has_marker;
    logic [PREFIX_W-1:0] prefix_chars;
  } result_t;

endpackage

// ----- rtl/tpip_char_if.sv -----
// Character channel: one code point per beat with end-of-input and previous indent.
// Depends on tpip_pkg for field widths.
interface tpip_char_if;
  logic                         valid;
  logic                         ready;
  logic [tpip_pkg::CHAR_W-1:0]  char_code;
  logic                         end_of_input;
  logic [tpip_pkg::PREV_W-1:0]  previous_indent;

  modport source (output valid, output char_code, output end_of_input,
                  output previous_indent, input ready);
  modport sink   (input valid, input char_code, input end_of_input,
                  input previous_indent, output ready);
endinterface

// ----- rtl/tpip_result_if.sv -----
// Result channel: one parsed prefix per beat.
// Depends on tpip_pkg for field widths.
interface tpip_result_if;
  logic                          valid;
  logic                          ready;
  logic [tpip_pkg::INDENT_W-1:0] indent_depth;
  logic                          has_marker;
  logic [tpip_pkg::PREFIX_W-1:0] prefix_chars;

  modport source (output valid, output indent_depth, output has_marker,
                  output prefix_chars, input ready);
  modport sink   (input valid, input indent_depth, input has_marker,
                  input prefix_chars, output ready);
endinterface

// ----- rtl/tpip_step.sv -----
// Next-state and result logic for one character of the tree prefix.
// Depends on tpip_pkg; instantiated by tree_prefix_indent_parser.
module tpip_step #(
  parameter int TAB_WIDTH        = tpip_pkg::TAB_WIDTH_DEF,
  parameter int MAX_PREFIX_CHARS = tpip_pkg::MAX_PREFIX_CHARS_DEF,
  parameter int CNT_W            = $clog2(MAX_PREFIX_CHARS + 1)
) (
  input  tpip_pkg::parse_ctl_t          ctl,
  input  logic [CNT_W-1:0]              count,
  input  logic [tpip_pkg::CHAR_W-1:0]   char_code,
  input  logic                          end_of_input,
  input  logic [tpip_pkg::PREV_W-1:0]   previous_indent,
  output tpip_pkg::parse_ctl_t          ctl_next,
  output logic [CNT_W-1:0]              count_next,
  output logic                          fire,
  output tpip_pkg::result_t             result
);

  localparam int LIM_W    = $clog2(((1 << tpip_pkg::PREV_W) - 1) * TAB_WIDTH + 1);
  localparam int CMP_W    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int IND_W    = (CNT_W + 1 > tpip_pkg::INDENT_W) ? CNT_W + 1 : tpip_pkg::INDENT_W;
  localparam int PFX_W    = (CNT_W > tpip_pkg::PREFIX_W) ? CNT_W : tpip_pkg::PREFIX_W;

  // Divide by the tab width with a rounded-up reciprocal; exact for tab widths up to 17
  localparam int RCP_S    = IND_W + 4;
  localparam int RCP_W    = RCP_S + 1;
  localparam int PROD_W   = IND_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(((1 << RCP_S) + TAB_WIDTH - 1) / TAB_WIDTH);

  tpip_pkg::char_class_t cls;
  tpip_pkg::parse_state_t eff_state;
  tpip_pkg::parse_ctl_t  ctl_work;
  logic [CNT_W-1:0]      cnt_inc;
  logic [LIM_W-1:0]      limit;
  logic [CMP_W-1:0]      cnt_cmp;
  logic [CMP_W-1:0]      lim_cmp;
  logic [CNT_W-1:0]      cols;
  logic [IND_W-1:0]      ind_sum;
  logic [PROD_W-1:0]     ind_prod;
  logic [IND_W-1:0]      ind_quo;
  logic [PFX_W-1:0]      cols_w;

  always_comb begin
    if ((char_code == tpip_pkg::CP_SPACE) || (char_code == tpip_pkg::CP_NBSP)) begin
      cls = tpip_pkg::CH_SPACE;
    end else if (char_code == tpip_pkg::CP_VBAR) begin
      cls = tpip_pkg::CH_VBAR;
    end else if ((char_code == tpip_pkg::CP_TEE) || (char_code == tpip_pkg::CP_CORNER)) begin
      cls = tpip_pkg::CH_BRANCH;
    end else if (char_code == tpip_pkg::CP_HBAR) begin
      cls = tpip_pkg::CH_HBAR;
    end else begin
      cls = tpip_pkg::CH_OTHER;
    end
  end

  // Saturating column count including the current character
  assign cnt_inc = (count < CNT_W'(MAX_PREFIX_CHARS)) ? count + CNT_W'(1) : count;
  assign limit   = LIM_W'(previous_indent) * LIM_W'(TAB_WIDTH);
  assign cnt_cmp = CMP_W'(cnt_inc);
  assign lim_cmp = CMP_W'(limit);

  always_comb begin
    ctl_work  = ctl;
    fire      = 1'b0;
    cols      = '0;
    eff_state = ctl.state;
    if (end_of_input) begin
      fire = 1'b1;
      cols = count;
    end else begin
      // Past the previous line's depth a vertical line turns into continuation
      if ((ctl.state == tpip_pkg::ST_VLINE) && (cnt_cmp > lim_cmp)) begin
        eff_state = tpip_pkg::ST_VCONT;
      end
      ctl_work.state = eff_state;
      unique case (eff_state)
        tpip_pkg::ST_VLINE: begin
          case (cls) inside
            tpip_pkg::CH_SPACE, tpip_pkg::CH_VBAR: ;
            tpip_pkg::CH_BRANCH: ctl_work.state = tpip_pkg::ST_BRANCH;
            default: fire = 1'b1;
          endcase
        end
        tpip_pkg::ST_VCONT: begin
          case (cls)
            tpip_pkg::CH_SPACE: ;
            tpip_pkg::CH_BRANCH: ctl_work.state = tpip_pkg::ST_BRANCH;
            default: begin
              // Rewind to the previous line's depth
              fire = 1'b1;
              cols = (cnt_cmp < lim_cmp) ? cnt_inc : CNT_W'(lim_cmp);
            end
          endcase
        end
        tpip_pkg::ST_BRANCH: begin
          ctl_work.marker_seen = 1'b1;
          case (cls)
            tpip_pkg::CH_HBAR: ctl_work.state = tpip_pkg::ST_HLINE;
            tpip_pkg::CH_SPACE: begin
              fire = 1'b1;
              cols = cnt_inc;
            end
            default: fire = 1'b1;
          endcase
        end
        tpip_pkg::ST_HLINE: begin
          ctl_work.marker_seen = 1'b1;
          case (cls)
            tpip_pkg::CH_HBAR: ;
            tpip_pkg::CH_SPACE: begin
              fire = 1'b1;
              cols = cnt_inc;
            end
            tpip_pkg::CH_BRANCH: fire = 1'b1;
            default: begin
              // Drop the current character from the prefix
              fire = 1'b1;
              cols = cnt_inc - CNT_W'(1);
            end
          endcase
        end
        default: begin
          case (cls)
            tpip_pkg::CH_SPACE: ;
            tpip_pkg::CH_VBAR: ctl_work.state = tpip_pkg::ST_VLINE;
            tpip_pkg::CH_BRANCH: ctl_work.state = tpip_pkg::ST_BRANCH;
            default: fire = 1'b1;
          endcase
        end
      endcase
    end
  end

  assign ind_sum  = IND_W'(cols) + IND_W'(TAB_WIDTH / 2);
  assign ind_prod = PROD_W'(ind_sum) * PROD_W'(RCP_M);
  assign ind_quo  = ind_prod[RCP_S +: IND_W];
  assign cols_w   = PFX_W'(cols);

  assign result.indent_depth = ind_quo[tpip_pkg::INDENT_W-1:0];
  assign result.has_marker   = ctl_work.marker_seen;
  assign result.prefix_chars = cols_w[tpip_pkg::PREFIX_W-1:0];

  // Start a fresh prefix after every result
  always_comb begin
    if (fire) begin
      ctl_next.state       = tpip_pkg::ST_START;
      ctl_next.marker_seen = 1'b0;
      count_next           = '0;
    end else begin
      ctl_next   = ctl_work;
      count_next = cnt_inc;
    end
  end

endmodule

// ----- rtl/tree_prefix_indent_parser.sv -----
// Top level of the tree-prefix indent parser: input register, parser state, result register.
// Depends on tpip_pkg, tpip_char_if, tpip_result_if and tpip_step.
//
// The parser takes one character beat per clock and returns one result beat whenever a
// tree-drawing prefix ends (normal end, content, error or end of input). Sustained rate is
// one character per cycle while no prefix-ending character waits on a full result register;
// a result is computed from the input register and presented from the result register. The
// rate is set by the loop through the parse state, marker flag and saturating column
// counter. The input register keeps taking beats while a result waits in the output
// register, as long as the waiting character does not itself end a prefix.
module tree_prefix_indent_parser #(
  parameter int TAB_WIDTH        = tpip_pkg::TAB_WIDTH_DEF,
  parameter int MAX_PREFIX_CHARS = tpip_pkg::MAX_PREFIX_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  tpip_char_if.sink          chars,
  tpip_result_if.source      results
);

  localparam int CNT_W = $clog2(MAX_PREFIX_CHARS + 1);

  // Input register
  logic                          s1_valid;
  logic [tpip_pkg::CHAR_W-1:0]   s1_char;
  logic                          s1_eoi;
  logic [tpip_pkg::PREV_W-1:0]   s1_prev;

  // Parser state
  tpip_pkg::parse_ctl_t          ctl;
  tpip_pkg::parse_ctl_t          ctl_next;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;

  // Result register
  logic                          out_valid;
  tpip_pkg::result_t             out_data;

  logic                          fire;
  tpip_pkg::result_t             step_result;
  logic                          advance;
  logic                          in_accept;

  tpip_step #(
    .TAB_WIDTH        (TAB_WIDTH),
    .MAX_PREFIX_CHARS (MAX_PREFIX_CHARS),
    .CNT_W            (CNT_W)
  ) u_step (
    .ctl             (ctl),
    .count           (count),
    .char_code       (s1_char),
    .end_of_input    (s1_eoi),
    .previous_indent (s1_prev),
    .ctl_next        (ctl_next),
    .count_next      (count_next),
    .fire            (fire),
    .result          (step_result)
  );

  // A character that ends a prefix needs room in the result register
  assign advance   = s1_valid && (!fire || !out_valid || results.ready);
  assign in_accept = chars.valid && chars.ready;

  assign chars.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char <= chars.char_code;
      s1_eoi  <= chars.end_of_input;
      s1_prev <= chars.previous_indent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.state       <= tpip_pkg::ST_START;
      ctl.marker_seen <= 1'b0;
      count           <= '0;
    end else if (advance) begin
      ctl   <= ctl_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      out_data <= step_result;
    end
  end

  assign results.valid        = out_valid;
  assign results.indent_depth = out_data.indent_depth;
  assign results.has_marker   = out_data.has_marker;
  assign results.prefix_chars = out_data.prefix_chars;

  // The marker is only ever held while walking a horizontal line
  assert property (@(posedge clk) disable iff (rst)
    ctl.marker_seen == (ctl.state == tpip_pkg::ST_HLINE))
    else $error("marker flag out of step with parse state");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PREFIX_CHARS))
    else $error("column count beyond saturation limit");

  // Every result restarts the parser
  assert property (@(posedge clk) disable iff (rst)
    (advance && fire) |=> (ctl.state == tpip_pkg::ST_START && count == '0 && out_valid))
    else $error("parser did not restart after a result");

  assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> (s1_valid && fire && out_valid && !results.ready))
    else $error("input stalled without a blocked result");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for tree_prefix_indent_parser: directed table, then random tree lines, long runs and noise.
// Depends on tpip_pkg, tpip_char_if, tpip_result_if and the parser RTL.
`timescale 1ns / 100ps

module tb_top;
  import tpip_pkg::*;

  localparam int TAB  = TAB_WIDTH_DEF;
  localparam int MAXC = MAX_PREFIX_CHARS_DEF;
  localparam int N_RANDOM = 1700;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eoi;
    logic [PREV_W-1:0] prev;
    logic              pinned;
    result_t           want;
  } dir_row_t;

  localparam result_t ANY = '0;
  localparam result_t NIL = '{7'd0, 1'b0, 8'd0};

  localparam int N_DIR = 24;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{21'h0,      1'b1, 6'd0,  1'b1, NIL},               // end of input right after reset
    '{21'h41,     1'b0, 6'd0,  1'b1, NIL},               // content at start
    '{CP_HBAR,    1'b0, 6'd63, 1'b1, NIL},               // horizontal bar at start
    '{CP_SPACE,   1'b0, 6'd0,  1'b0, ANY},
    '{CP_TEE,     1'b0, 6'd0,  1'b0, ANY},
    '{CP_SPACE,   1'b0, 6'd0,  1'b0, ANY},               // normal end after branch glyph
    '{CP_VBAR,    1'b0, 6'd1,  1'b0, ANY},
    '{CP_SPACE,   1'b0, 6'd1,  1'b0, ANY},
    '{CP_NBSP,    1'b0, 6'd1,  1'b0, ANY},
    '{CP_SPACE,   1'b0, 6'd1,  1'b0, ANY},
    '{21'h7A,     1'b0, 6'd1,  1'b0, ANY},               // continuation, then partial rewind
    '{CP_VBAR,    1'b0, 6'd2,  1'b0, ANY},
    '{21'h10FFFF, 1'b0, 6'd2,  1'b1, NIL},               // bad character in vertical line
    '{CP_TEE,     1'b0, 6'd0,  1'b0, ANY},
    '{21'h1FFFFF, 1'b1, 6'd0,  1'b1, '{7'd0, 1'b0, 8'd1}}, // eoi right after branch glyph
    '{CP_TEE,     1'b0, 6'd0,  1'b0, ANY},
    '{21'h78,     1'b0, 6'd0,  1'b1, '{7'd0, 1'b1, 8'd0}}, // bad character in branch
    '{CP_CORNER,  1'b0, 6'd0,  1'b0, ANY},
    '{CP_HBAR,    1'b0, 6'd0,  1'b0, ANY},
    '{CP_TEE,     1'b0, 6'd0,  1'b1, '{7'd0, 1'b1, 8'd0}}, // branch glyph in horizontal line
    '{CP_CORNER,  1'b0, 6'd0,  1'b0, ANY},
    '{CP_HBAR,    1'b0, 6'd0,  1'b0, ANY},
    '{CP_HBAR,    1'b0, 6'd0,  1'b0, ANY},
    '{21'h1FFFFF, 1'b0, 6'd0,  1'b0, ANY}                // single rewind in horizontal line
  };

  logic clk = 1'b0;
  logic rst;

  tpip_char_if   chars_if ();
  tpip_result_if res_if ();

  tree_prefix_indent_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  // Predictor state
  parse_state_t p_state;
  int           p_cols;
  bit           p_marker;

  result_t prefix_q[$];
  result_t want_r;
  int      n_errors;
  int      n_sent;
  bit      calm;
  bit      held;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Advance the predictor by one character; return 1 when the prefix ends.
  function automatic bit predict_prefix(input logic [CHAR_W-1:0] ch, input logic eoi,
                                        input logic [PREV_W-1:0] prev, output result_t res);
    int lim;
    int n;
    bit done;
    bit sp;
    bit br;
    lim  = int'(prev) * TAB;
    n    = 0;
    done = 1'b0;
    res  = '0;
    if (eoi) begin
      done = 1'b1;
      n    = p_cols;
    end else begin
      if (p_cols < MAXC) p_cols++;
      sp = (ch == CP_SPACE) || (ch == CP_NBSP);
      br = (ch == CP_TEE) || (ch == CP_CORNER);
      if (p_state == ST_VLINE && p_cols > lim) p_state = ST_VCONT;
      case (p_state)
        ST_VLINE: begin
          if (sp || ch == CP_VBAR) begin
          end else if (br) begin
            p_state = ST_BRANCH;
          end else begin
            done = 1'b1;
          end
        end
        ST_VCONT: begin
          if (sp) begin
          end else if (br) begin
            p_state = ST_BRANCH;
          end else begin
            done = 1'b1;
            n    = (p_cols < lim) ? p_cols : lim;
          end
        end
        ST_BRANCH: begin
          p_marker = 1'b1;
          if (ch == CP_HBAR) begin
            p_state = ST_HLINE;
          end else begin
            done = 1'b1;
            n    = sp ? p_cols : 0;
          end
        end
        ST_HLINE: begin
          p_marker = 1'b1;
          if (ch != CP_HBAR) begin
            done = 1'b1;
            if (sp) n = p_cols;
            else if (br) n = 0;
            else n = p_cols - 1;
          end
        end
        default: begin
          if (sp) begin
          end else if (ch == CP_VBAR) begin
            p_state = ST_VLINE;
          end else if (br) begin
            p_state = ST_BRANCH;
          end else begin
            done = 1'b1;
          end
        end
      endcase
    end
    if (done) begin
      res.indent_depth = INDENT_W'((n + TAB / 2) / TAB);
      res.has_marker   = p_marker;
      res.prefix_chars = PREFIX_W'(n);
      p_state  = ST_START;
      p_cols   = 0;
      p_marker = 1'b0;
    end
    return done;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_pad();
    return ($urandom_range(3) == 0) ? CP_NBSP : CP_SPACE;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_content();
    return ($urandom_range(1) == 0) ? CHAR_W'($urandom_range(126, 33)) : CHAR_W'($urandom);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_glyph();
    case ($urandom_range(9))
      0: return CP_SPACE;
      1: return CP_NBSP;
      2: return CP_VBAR;
      3: return CP_TEE;
      4: return CP_CORNER;
      5: return CP_HBAR;
      6: return CP_VBAR ^ CHAR_W'(1 << $urandom_range(CHAR_W - 1));
      7: return CHAR_W'($urandom_range(126, 33));
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eoi,
                           input logic [PREV_W-1:0] prev, input bit pinned = 1'b0,
                           input result_t want = '0);
    result_t res;
    bit      ends;
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        chars_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    chars_if.valid           <= 1'b1;
    chars_if.char_code       <= ch;
    chars_if.end_of_input    <= eoi;
    chars_if.previous_indent <= prev;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    ends = predict_prefix(ch, eoi, prev, res);
    if (pinned) prefix_q = {prefix_q, want};
    else if (ends) prefix_q = {prefix_q, res};
    n_sent++;
  endtask

  // Occasionally swap a character for arbitrary glyph noise.
  function automatic logic [CHAR_W-1:0] maybe_break(input logic [CHAR_W-1:0] ch);
    return ($urandom_range(39) == 0) ? pick_glyph() : ch;
  endfunction

  task automatic tree_line();
    int prev;
    int depth;
    int i;
    int j;
    logic [PREV_W-1:0] pv;
    if ($urandom_range(59) == 0) begin
      prev  = $urandom_range(63, 48);
      depth = $urandom_range(prev + 1, prev - 8);
    end else begin
      prev  = $urandom_range(5);
      depth = $urandom_range(prev + 1);
    end
    pv = PREV_W'(prev);
    for (i = 0; i < depth; i++) begin
      if ($urandom_range(3) == 0) send_char(maybe_break(pick_pad()), 1'b0, pv);
      else send_char(maybe_break(CP_VBAR), 1'b0, pv);
      for (j = 0; j < 3; j++) send_char(maybe_break(pick_pad()), 1'b0, pv);
    end
    if ($urandom_range(5) != 0) begin
      send_char($urandom_range(1) ? CP_TEE : CP_CORNER, 1'b0, pv);
      j = $urandom_range(3);
      for (i = 0; i < j; i++) send_char(maybe_break(CP_HBAR), 1'b0, pv);
      case ($urandom_range(7))
        0, 1, 2, 3: send_char(pick_pad(), 1'b0, pv);
        4: send_char(pick_content(), 1'b0, pv);
        5: send_char($urandom_range(1) ? CP_TEE : CP_CORNER, 1'b0, pv);
        6: send_char(CHAR_W'($urandom), 1'b1, pv);
        default: send_char(CP_HBAR, 1'b0, pv);
      endcase
    end
    j = $urandom_range(2);
    for (i = 0; i < j; i++) send_char(pick_content(), 1'b0, pv);
    if ($urandom_range(2) == 0) send_char(CHAR_W'($urandom), 1'b1, pv);
  endtask

  // Run past the column limit so the counter saturates.
  task automatic long_run();
    int len;
    int i;
    len = $urandom_range(300, 260);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) send_char(CP_VBAR, 1'b0, 6'd63);
      else send_char(pick_pad(), 1'b0, 6'd63);
    end
    if ($urandom_range(1) == 0) begin
      send_char(CHAR_W'($urandom), 1'b1, 6'd63);
    end else begin
      send_char(CP_TEE, 1'b0, 6'd63);
      send_char(CP_SPACE, 1'b0, 6'd63);
    end
  endtask

  task automatic noise_burst();
    int len;
    int i;
    len = $urandom_range(12, 1);
    for (i = 0; i < len; i++)
      send_char(pick_glyph(), ($urandom_range(7) == 0), PREV_W'($urandom));
  endtask

  // Result side: check each beat, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (prefix_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, prefix_chars",
                          int'(res_if.prefix_chars), -1);
        end else begin
          want_r = prefix_q.pop_front();
          if (res_if.indent_depth !== want_r.indent_depth)
            report_mismatch("indent_depth", int'(res_if.indent_depth),
                            int'(want_r.indent_depth));
          if (res_if.has_marker !== want_r.has_marker)
            report_mismatch("has_marker", int'(res_if.has_marker),
                            int'(want_r.has_marker));
          if (res_if.prefix_chars !== want_r.prefix_chars)
            report_mismatch("prefix_chars", int'(res_if.prefix_chars),
                            int'(want_r.prefix_chars));
        end
      end
      res_if.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int lines;
    int k;
    rst                      = 1'b1;
    chars_if.valid           = 1'b0;
    chars_if.char_code       = '0;
    chars_if.end_of_input    = 1'b0;
    chars_if.previous_indent = '0;
    p_state  = ST_START;
    p_cols   = 0;
    p_marker = 1'b0;
    n_errors = 0;
    n_sent   = 0;
    calm     = 1'b0;
    held     = 1'b0;
    lines    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_DIR; k++)
      send_char(DIRECTED[k].ch, DIRECTED[k].eoi, DIRECTED[k].prev,
                DIRECTED[k].pinned, DIRECTED[k].want);

    while (n_sent < N_DIR + N_RANDOM) begin
      calm = (n_sent >= 900) && (n_sent < 1200);
      if (!held && n_sent >= 600) begin
        // hold the input until the parser has drained
        held = 1'b1;
        chars_if.valid <= 1'b0;
        while (prefix_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end
      k = $urandom_range(99);
      if (lines == 50 || $urandom_range(119) == 0) long_run();
      else if (k < 75) tree_line();
      else noise_burst();
      lines++;
    end
    calm = 1'b0;
    chars_if.valid <= 1'b0;

    while (prefix_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- tree_prefix_indent_parser.f -----
rtl/tpip_pkg.sv
rtl/tpip_char_if.sv
rtl/tpip_result_if.sv
rtl/tpip_step.sv
rtl/tree_prefix_indent_parser.sv
tb/sv/tb_top.sv
